[src/pip_pkg.sv]
// ----------------------------------------------------------------------------
// pip_pkg
// Shared constants, codes and controller/datapath link types for the
// point-in-polygon crossing-number block.
// ----------------------------------------------------------------------------
package pip_pkg;

   localparam int DEF_MAX_VERTICES   = 16;
   localparam int DEF_COORD_WIDTH    = 16;

   localparam int VERTEX_COUNT_WIDTH = 5;
   localparam int VERTEX_INDEX_WIDTH = 4;
   localparam logic [VERTEX_COUNT_WIDTH-1:0] VERTEX_COUNT_RESET = 5'd3;

   // request codes
   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   // APB register map (word index taken from paddr[2])
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;
   localparam logic CSR_IDX_VERTEX_COUNT = 1'b0;

   typedef struct packed {
      logic write;     // store the incoming vertex
      logic start;     // query accepted: capture point, clear parity
      logic issue;     // vertex read issued this cycle
      logic first;     // this read primes the previous-vertex register
      logic load_out;  // copy parity into the result register
   } pip_cmd_type;

   typedef struct packed {
      logic busy;      // edge pipeline still holds work
   } pip_stat_type;

endpackage

[src/pip_req_if.sv]
// ----------------------------------------------------------------------------
// pip_req_if
// Request channel: vertex load or point query, valid/ready handshake.
// ----------------------------------------------------------------------------
interface pip_req_if
   import pip_pkg::*;
#(
   parameter int COORD_WIDTH = DEF_COORD_WIDTH
) ();
   logic                                valid;
   logic                                ready;
   logic                                req_type;
   logic [VERTEX_INDEX_WIDTH-1:0]       vertex_index;
   logic signed [COORD_WIDTH-1:0]       point_x;
   logic signed [COORD_WIDTH-1:0]       point_y;

   modport source (output valid, req_type, vertex_index, point_x, point_y, input ready);
   modport sink   (input valid, req_type, vertex_index, point_x, point_y, output ready);
endinterface

[src/pip_rsp_if.sv]
// ----------------------------------------------------------------------------
// pip_rsp_if
// Result channel: one inside flag per query, valid/ready handshake.
// ----------------------------------------------------------------------------
interface pip_rsp_if;
   logic valid;
   logic ready;
   logic inside_res;

   modport source (output valid, inside_res, input ready);
   modport sink   (input valid, inside_res, output ready);
endinterface

[src/pip_ram.sv]
// ----------------------------------------------------------------------------
// pip_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pip_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

[src/pip_dp.sv]
// ----------------------------------------------------------------------------
// pip_dp
// Edge datapath: vertex store, previous-vertex register, difference stage,
// product stage and parity compare stage.
// ----------------------------------------------------------------------------
module pip_dp
   import pip_pkg::*;
#(
   parameter int MAX_VERTICES = DEF_MAX_VERTICES,
   parameter int COORD_WIDTH  = DEF_COORD_WIDTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  pip_cmd_type                     cmd,
   input  logic [$clog2(MAX_VERTICES)-1:0] rd_addr,
   input  logic [VERTEX_INDEX_WIDTH-1:0]   vertex_index,
   input  logic signed [COORD_WIDTH-1:0]   point_x,
   input  logic signed [COORD_WIDTH-1:0]   point_y,
   output pip_stat_type                    stat,
   output logic                            inside_res
);
   localparam int AW = $clog2(MAX_VERTICES);
   localparam int DW = COORD_WIDTH + 1;
   localparam int PW = 2 * DW;

   logic [2*COORD_WIDTH-1:0]      rd_data;
   logic signed [COORD_WIDTH-1:0] cur_x, cur_y;

   logic signed [COORD_WIDTH-1:0] px_ff, py_ff, prev_x_ff, prev_y_ff;
   logic                          rd_v_ff, rd_first_ff;
   logic                          s1_v_ff, s2_v_ff, s2_neg_ff;
   logic signed [DW-1:0]          s1_dy_ff, s1_dx_ff, s1_a_ff, s1_b_ff;
   logic signed [DW-1:0]          dy_in, dx_in, a_in, b_in;
   logic signed [PW-1:0]          prod_l, prod_r, s2_pl_ff, s2_pr_ff;
   logic                          straddle, hit;
   logic                          parity_ff, parity_in;
   logic                          inside_res_ff;

   pip_ram #(.WIDTH(2 * COORD_WIDTH), .DEPTH(MAX_VERTICES)) u_store (
      .clock   (clock),
      .wr_en   (cmd.write),
      .wr_addr (AW'(vertex_index)),
      .wr_data ({point_x, point_y}),
      .rd_en   (cmd.issue),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign cur_x = rd_data[2*COORD_WIDTH-1:COORD_WIDTH];
   assign cur_y = rd_data[COORD_WIDTH-1:0];

   // edge j -> i, j held in prev_*
   assign straddle = (cur_y > py_ff) != (prev_y_ff > py_ff);
   assign dy_in    = DW'(prev_y_ff) - DW'(cur_y);
   assign dx_in    = DW'(prev_x_ff) - DW'(cur_x);
   assign a_in     = DW'(px_ff) - DW'(cur_x);
   assign b_in     = DW'(py_ff) - DW'(cur_y);

   assign prod_l = s1_a_ff * s1_dy_ff;
   assign prod_r = s1_dx_ff * s1_b_ff;

   // dy > 0: a*dy < dx*b ; dy < 0: a*dy > dx*b
   assign hit       = s2_neg_ff ? (s2_pl_ff > s2_pr_ff) : (s2_pl_ff < s2_pr_ff);
   assign parity_in = cmd.start ? 1'b0 : (parity_ff ^ (s2_v_ff & hit));

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_v_ff   <= 1'b0;
         s1_v_ff   <= 1'b0;
         s2_v_ff   <= 1'b0;
         parity_ff <= 1'b0;
      end else begin
         rd_v_ff   <= cmd.issue;
         s1_v_ff   <= rd_v_ff & ~rd_first_ff & straddle;
         s2_v_ff   <= s1_v_ff;
         parity_ff <= parity_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         px_ff <= point_x;
         py_ff <= point_y;
      end
      if (cmd.issue) begin
         rd_first_ff <= cmd.first;
      end
      if (rd_v_ff) begin
         prev_x_ff <= cur_x;
         prev_y_ff <= cur_y;
         s1_dy_ff  <= dy_in;
         s1_dx_ff  <= dx_in;
         s1_a_ff   <= a_in;
         s1_b_ff   <= b_in;
      end
      if (s1_v_ff) begin
         s2_pl_ff  <= prod_l;
         s2_pr_ff  <= prod_r;
         s2_neg_ff <= s1_dy_ff[DW-1];
      end
      if (cmd.load_out) begin
         inside_res_ff <= parity_ff;
      end
   end

   assign stat.busy  = rd_v_ff | s1_v_ff | s2_v_ff;
   assign inside_res = inside_res_ff;

`ifndef SYNTHESIS
   // parity moves only on a counted edge or a new query
   a_parity_quiet: assert property (@(posedge clock) disable iff (reset)
      (!s2_v_ff && !cmd.start) |=> $stable(parity_ff))
      else $error("parity changed without an edge result");
`endif
endmodule

[src/pip_ctrl.sv]
// ----------------------------------------------------------------------------
// pip_ctrl
// Sequencer: request handshake, vertex_count register, edge walk and
// result register handshake.
// ----------------------------------------------------------------------------
module pip_ctrl
   import pip_pkg::*;
#(
   parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_type,
   input  logic [VERTEX_INDEX_WIDTH-1:0]   vertex_index,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0]       csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0]       csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0]       csr_prdata,
   output pip_cmd_type                     cmd,
   output logic [$clog2(MAX_VERTICES)-1:0] rd_addr,
   input  pip_stat_type                    stat
);
   localparam int AW = $clog2(MAX_VERTICES);
   localparam int CW = $clog2(MAX_VERTICES + 1);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_READ  = 2'd1;
   localparam logic [1:0] S_DRAIN = 2'd2;

   logic [1:0]                    state_ff, state_in;
   logic [CW-1:0]                 cnt_ff, cnt_in;
   logic [VERTEX_COUNT_WIDTH-1:0] vertex_count_ff, vertex_count_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]                 n_used;
   logic                          req_xfer, csr_wr, out_free;

   assign csr_wr = csr_psel & csr_penable & csr_pwrite
                   & (csr_paddr[2] == CSR_IDX_VERTEX_COUNT);
   assign vertex_count_in = csr_wr ? csr_pwdata[VERTEX_COUNT_WIDTH-1:0] : vertex_count_ff;
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_VERTEX_COUNT)
                       ? CSR_DATA_WIDTH'(vertex_count_ff) : '0;

   // counts above the store depth saturate
   assign n_used = (32'(vertex_count_ff) > 32'(MAX_VERTICES))
                   ? CW'(MAX_VERTICES) : CW'(vertex_count_ff);

   assign req_ready = (state_ff == S_IDLE);
   assign req_xfer  = req_valid & req_ready;
   assign out_free  = ~rsp_valid_ff | rsp_ready;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cmd          = '0;
      rd_addr      = '0;
      cmd.write    = req_xfer & (req_type == REQ_LOAD)
                     & (32'(vertex_index) < 32'(MAX_VERTICES));
      case (state_ff)
         S_IDLE: begin
            if (req_xfer && req_type == REQ_QUERY) begin
               cmd.start = 1'b1;
               cnt_in    = '0;
               state_in  = (n_used == '0) ? S_DRAIN : S_READ;
            end
         end
         S_READ: begin
            // first read fetches the closing vertex, then 0 .. n-1
            cmd.issue = 1'b1;
            cmd.first = (cnt_ff == '0);
            rd_addr   = (cnt_ff == '0) ? AW'(n_used - 1'b1) : AW'(cnt_ff - 1'b1);
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == n_used) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (!stat.busy && out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.load_out ? 1'b1 : (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         cnt_ff          <= '0;
         vertex_count_ff <= VERTEX_COUNT_RESET;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         cnt_ff          <= cnt_in;
         vertex_count_ff <= vertex_count_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_query_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_type == REQ_QUERY) |=> (state_ff != S_IDLE))
      else $error("query transfer did not start a walk");
   a_result_after_drain: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!stat.busy && state_ff == S_DRAIN))
      else $error("result taken while edge pipeline busy");
   a_rsp_rise_from_drain: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DRAIN))
      else $error("result raised outside drain");
`endif
endmodule

[src/point_in_polygon_test.sv]
// ----------------------------------------------------------------------------
// point_in_polygon_test
// Even-odd crossing test of a point against a stored polygon.
// Load: one transfer, no result; next request taken next cycle.
// Query: n = min(vertex_count, MAX_VERTICES); n + 1 reads on the single store
//   read port (none when n is zero), then a three-stage edge pipe; the result is
//   raised once the pipe has drained and the previous result has been taken.
// Next request taken as the result is raised.
// Synchronous reset: vertex_count = 3, idle; vertex store is not cleared.
// ----------------------------------------------------------------------------
module point_in_polygon_test
   import pip_pkg::*;
#(
   parameter int MAX_VERTICES = DEF_MAX_VERTICES,
   parameter int COORD_WIDTH  = DEF_COORD_WIDTH
) (
   input  logic                      clock,
   input  logic                      reset,
   pip_req_if.sink                   req_chan,
   pip_rsp_if.source                 rsp_chan,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready
);
   pip_cmd_type                     cmd;
   pip_stat_type                    stat;
   logic [$clog2(MAX_VERTICES)-1:0] rd_addr;

   // register writes complete in the access phase, never stalled
   assign csr_pready = 1'b1;

   // Controller: accepts one request transfer at a time, walks the edges
   // through the store and raises the result once the pipeline empties.
   pip_ctrl #(.MAX_VERTICES(MAX_VERTICES)) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_chan.valid),
      .req_ready    (req_chan.ready),
      .req_type     (req_chan.req_type),
      .vertex_index (req_chan.vertex_index),
      .rsp_valid    (rsp_chan.valid),
      .rsp_ready    (rsp_chan.ready),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .cmd          (cmd),
      .rd_addr      (rd_addr),
      .stat         (stat)
   );

   // Datapath: vertex store plus a three-stage edge pipe (differences,
   // exact cross products, signed compare into the parity bit).
   pip_dp #(.MAX_VERTICES(MAX_VERTICES), .COORD_WIDTH(COORD_WIDTH)) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .rd_addr      (rd_addr),
      .vertex_index (req_chan.vertex_index),
      .point_x      (req_chan.point_x),
      .point_y      (req_chan.point_y),
      .stat         (stat),
      .inside_res   (rsp_chan.inside_res)
   );
endmodule
